@@ design/tce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared sizes, codes and controller/datapath signal groups of the execute unit.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int REG_COUNT   = 16;
    localparam int STACK_DEPTH = 64;
    localparam int MEM_WORDS   = 256;

    localparam int WORD_W    = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int MEM_IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 80;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_BR   = 5'd1;
    localparam logic [4:0] OP_BEQ  = 5'd2;
    localparam logic [4:0] OP_BNE  = 5'd3;
    localparam logic [4:0] OP_BG   = 5'd4;
    localparam logic [4:0] OP_BL   = 5'd5;
    localparam logic [4:0] OP_BGE  = 5'd6;
    localparam logic [4:0] OP_BLE  = 5'd7;
    localparam logic [4:0] OP_PUSH = 5'd8;
    localparam logic [4:0] OP_POP  = 5'd9;
    localparam logic [4:0] OP_ADD  = 5'd10;
    localparam logic [4:0] OP_SUB  = 5'd11;
    localparam logic [4:0] OP_MUL  = 5'd12;
    localparam logic [4:0] OP_DIV  = 5'd13;
    localparam logic [4:0] OP_MOD  = 5'd14;
    localparam logic [4:0] OP_MOV  = 5'd15;
    localparam logic [4:0] OP_LDR  = 5'd16;
    localparam logic [4:0] OP_STR  = 5'd17;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;

    localparam logic [3:0] ST_OK    = 4'd0;
    localparam logic [3:0] ST_HALT  = 4'd1;
    localparam logic [3:0] ST_DEST  = 4'd2;
    localparam logic [3:0] ST_KIND  = 4'd3;
    localparam logic [3:0] ST_DIVZ  = 4'd4;
    localparam logic [3:0] ST_FULL  = 4'd5;
    localparam logic [3:0] ST_EMPTY = 4'd6;
    localparam logic [3:0] ST_ADDR  = 4'd7;
    localparam logic [3:0] ST_REG   = 4'd8;
    localparam logic [3:0] ST_OP    = 4'd9;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SECOND,
        RD_THIRD,
        RD_FIRST
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        t_rd_sel rd_sel;
        logic    check;
        logic    mul_en;
        logic    div_start;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic is_mul;
        logic is_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ design/tce_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_div
// Iterative signed divider: one quotient bit per cycle, truncating quotient
// and a remainder that takes the sign of the dividend.
// ----------------------------------------------------------------------------
module tce_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tce_pkg::WORD_W-1:0] i_dividend,
    input  logic [tce_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [tce_pkg::WORD_W-1:0] o_quot,
    output logic [tce_pkg::WORD_W-1:0] o_rem
);
    import tce_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_quot;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvsr;
    logic              r_neg_q;
    logic              r_neg_r;
    logic [WORD_W:0]   n_trial;
    logic [WORD_W-1:0] n_shift;

    always_comb begin
        n_shift = {r_rem[WORD_W-2:0], r_quot[WORD_W-1]};
        n_trial = {1'b0, n_shift} - {1'b0, r_dvsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(WORD_W);
                r_quot  <= i_dividend[WORD_W-1] ? -i_dividend : i_dividend;
                r_dvsr  <= i_divisor[WORD_W-1] ? -i_divisor : i_divisor;
                r_rem   <= '0;
                r_neg_q <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
                r_neg_r <= i_dividend[WORD_W-1];
            end else if (r_busy) begin
                // Restoring step: shift the next dividend bit into the remainder.
                if (!n_trial[WORD_W]) begin
                    r_rem <= n_trial[WORD_W-1:0];
                end else begin
                    r_rem <= n_shift;
                end
                r_quot <= {r_quot[WORD_W-2:0], ~n_trial[WORD_W]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg_q ? -r_quot : r_quot;
    assign o_rem  = r_neg_r ? -r_rem : r_rem;

endmodule

@@ design/tce_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer of the execute unit: operand reads, checks, multi-cycle
// arithmetic and the final commit of one instruction.
// ----------------------------------------------------------------------------
module tce_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tce_pkg::t_sts i_sts,
    output tce_pkg::t_cmd o_cmd
);
    import tce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SECOND,
        S_RD_THIRD,
        S_RD_FIRST,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RD_SECOND;
                end
            end
            S_RD_SECOND: begin
                o_cmd.rd_sel = RD_SECOND;
                n_state      = S_RD_THIRD;
            end
            S_RD_THIRD: begin
                o_cmd.rd_sel = RD_THIRD;
                n_state      = S_RD_FIRST;
            end
            S_RD_FIRST: begin
                o_cmd.rd_sel = RD_FIRST;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.ok && i_sts.is_mul) begin
                    n_state = S_MUL;
                end else if (i_sts.ok && i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ design/tce_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_datapath
// Register file, stack, data memory, checks, arithmetic and result register.
// ----------------------------------------------------------------------------
module tce_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tce_pkg::t_cmd                  i_cmd,
    output tce_pkg::t_sts                  o_sts,
    input  logic [tce_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [tce_pkg::IN_USER_W-1:0]  i_in_user,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tce_pkg::OUT_DATA_W-1:0] o_out_data
);
    import tce_pkg::*;

    // Captured instruction.
    logic [4:0]        r_op;
    logic [1:0]        r_k1, r_k2, r_k3;
    logic [WORD_W-1:0] r_v1, r_v2, r_v3;

    // Operand values and register-read faults.
    logic [WORD_W-1:0] r_a, r_b, r_c;
    logic              r_bad1, r_bad2, r_bad3;

    // Architectural state.
    logic [WORD_W-1:0]    r_rf [REG_COUNT];
    logic [WORD_W-1:0]    r_stack [STACK_DEPTH];
    logic [STK_CNT_W-1:0] r_count;
    logic [WORD_W-1:0]    r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_mem_vld;

    logic [WORD_W-1:0] r_stk_rd;
    logic [WORD_W-1:0] r_mem_rd;
    logic              r_mem_rd_vld;
    logic [WORD_W-1:0] r_prod;

    logic [3:0]        r_status;
    logic              r_taken;

    logic              r_out_valid;
    logic [3:0]        r_o_status;
    logic              r_o_taken;
    logic [WORD_W-1:0] r_o_offs;
    logic              r_o_wr;
    logic [3:0]        r_o_widx;
    logic [WORD_W-1:0] r_o_wval;

    logic              div_done;
    logic [WORD_W-1:0] div_quot;
    logic [WORD_W-1:0] div_rem;

    logic [1:0]        rd_kind;
    logic [WORD_W-1:0] rd_raw;
    logic              rd_bad;
    logic [WORD_W-1:0] rd_val;

    logic [3:0]        n_status;
    logic              n_taken;
    logic              cond;
    logic              dst_bad;
    logic              addr_bad;
    logic              wr_reg;
    logic [WORD_W-1:0] wval;

    logic [REG_IDX_W-1:0] widx;
    logic [MEM_IDX_W-1:0] maddr;

    assign widx  = r_v1[REG_IDX_W-1:0];
    assign maddr = r_v2[MEM_IDX_W-1:0];

    // Operand read port: one operand per cycle.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_SECOND: begin
                rd_kind = r_k2;
                rd_raw  = r_v2;
            end
            RD_THIRD: begin
                rd_kind = r_k3;
                rd_raw  = r_v3;
            end
            default: begin
                rd_kind = r_k1;
                rd_raw  = r_v1;
            end
        endcase
        rd_bad = (rd_kind == KIND_REG) && (rd_raw >= WORD_W'(REG_COUNT));
        if (rd_kind == KIND_REG) begin
            rd_val = rd_bad ? '0 : r_rf[rd_raw[REG_IDX_W-1:0]];
        end else if (rd_kind == KIND_IMM) begin
            rd_val = rd_raw;
        end else begin
            rd_val = '0;
        end
    end

    // Checks in the order the instruction set defines them.
    always_comb begin
        dst_bad  = (r_v1 >= WORD_W'(REG_COUNT));
        addr_bad = (r_v2 >= WORD_W'(MEM_WORDS));
        n_taken  = 1'b0;
        n_status = ST_OK;
        case (r_op)
            OP_BEQ:  cond = ($signed(r_a) == $signed(r_b));
            OP_BNE:  cond = ($signed(r_a) != $signed(r_b));
            OP_BG:   cond = ($signed(r_a) > $signed(r_b));
            OP_BL:   cond = ($signed(r_a) < $signed(r_b));
            OP_BGE:  cond = ($signed(r_a) >= $signed(r_b));
            default: cond = ($signed(r_a) <= $signed(r_b));
        endcase
        unique case (r_op) inside
            OP_HALT: n_status = ST_HALT;
            [OP_BR:OP_BLE]: begin
                if (r_op != OP_BR && (r_bad2 || r_bad3)) begin
                    n_status = ST_REG;
                end else if (r_op == OP_BR || cond) begin
                    if (r_bad1) begin
                        n_status = ST_REG;
                    end else begin
                        n_taken = 1'b1;
                    end
                end
            end
            OP_PUSH: begin
                if (r_bad1) begin
                    n_status = ST_REG;
                end else if (r_count >= STK_CNT_W'(STACK_DEPTH)) begin
                    n_status = ST_FULL;
                end
            end
            OP_POP: begin
                if (r_k1 != KIND_REG) begin
                    n_status = ST_DEST;
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (dst_bad) begin
                    n_status = ST_REG;
                end
            end
            [OP_ADD:OP_MOD]: begin
                if (r_k1 != KIND_REG) begin
                    n_status = ST_DEST;
                end else if (r_bad2 || r_bad3) begin
                    n_status = ST_REG;
                end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_b == '0) begin
                    n_status = ST_DIVZ;
                end else if (dst_bad) begin
                    n_status = ST_REG;
                end
            end
            OP_MOV: begin
                if (r_k1 != KIND_REG) begin
                    n_status = ST_DEST;
                end else if (r_k2 != KIND_REG && r_k2 != KIND_IMM) begin
                    n_status = ST_KIND;
                end else if (r_bad2 || dst_bad) begin
                    n_status = ST_REG;
                end
            end
            OP_LDR: begin
                if (r_k1 != KIND_REG) begin
                    n_status = ST_DEST;
                end else if (r_k2 != KIND_IMM) begin
                    n_status = ST_KIND;
                end else if (addr_bad) begin
                    n_status = ST_ADDR;
                end else if (dst_bad) begin
                    n_status = ST_REG;
                end
            end
            OP_STR: begin
                if (r_k1 != KIND_REG) begin
                    n_status = ST_DEST;
                end else if (r_k2 != KIND_IMM) begin
                    n_status = ST_KIND;
                end else if (r_bad1) begin
                    n_status = ST_REG;
                end else if (addr_bad) begin
                    n_status = ST_ADDR;
                end
            end
            default: n_status = ST_OP;
        endcase
    end

    // Register write value, selected once the instruction has finished.
    always_comb begin
        wr_reg = (r_status == ST_OK) &&
                 ((r_op >= OP_ADD && r_op <= OP_LDR) || r_op == OP_POP);
        case (r_op)
            OP_POP:  wval = r_stk_rd;
            OP_ADD:  wval = r_a + r_b;
            OP_SUB:  wval = r_a - r_b;
            OP_MUL:  wval = r_prod;
            OP_DIV:  wval = div_quot;
            OP_MOD:  wval = div_rem;
            OP_MOV:  wval = r_a;
            default: wval = r_mem_rd_vld ? r_mem_rd : '0;
        endcase
    end

    tce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Instruction, operand and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_data[4:0];
            r_v1 <= i_in_data[36:5];
            r_v2 <= i_in_data[68:37];
            r_v3 <= i_in_data[100:69];
            r_k1 <= i_in_user[1:0];
            r_k2 <= i_in_user[3:2];
            r_k3 <= i_in_user[5:4];
        end
        case (i_cmd.rd_sel)
            RD_SECOND: begin
                r_a    <= rd_val;
                r_bad2 <= rd_bad;
            end
            RD_THIRD: begin
                r_b    <= rd_val;
                r_bad3 <= rd_bad;
            end
            RD_FIRST: begin
                r_c    <= rd_val;
                r_bad1 <= rd_bad;
            end
            default: ;
        endcase
        if (i_cmd.rd_sel == RD_SECOND) begin
            r_stk_rd     <= r_stack[STK_IDX_W'(r_count - 1'b1)];
            r_mem_rd     <= r_mem[maddr];
            r_mem_rd_vld <= r_mem_vld[maddr];
        end
        if (i_cmd.check) begin
            r_status <= n_status;
            r_taken  <= n_taken;
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.commit) begin
            r_o_status <= r_status;
            r_o_taken  <= r_taken;
            r_o_offs   <= r_taken ? r_c : '0;
            r_o_wr     <= wr_reg;
            r_o_widx   <= wr_reg ? 4'(widx) : 4'd0;
            r_o_wval   <= wr_reg ? wval : '0;
        end
    end

    // Stack and data memory arrays.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_status == ST_OK && r_op == OP_PUSH) begin
            r_stack[r_count[STK_IDX_W-1:0]] <= r_c;
        end
        if (i_cmd.commit && r_status == ST_OK && r_op == OP_STR) begin
            r_mem[maddr] <= r_c;
        end
    end

    // Architectural control state with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mem_vld   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (wr_reg) begin
                    r_rf[widx] <= wval;
                end
                if (r_status == ST_OK && r_op == OP_PUSH) begin
                    r_count <= r_count + 1'b1;
                end
                if (r_status == ST_OK && r_op == OP_POP) begin
                    r_count <= r_count - 1'b1;
                end
                if (r_status == ST_OK && r_op == OP_STR) begin
                    r_mem_vld[maddr] <= 1'b1;
                end
            end
        end
    end

    assign o_sts.ok       = (n_status == ST_OK);
    assign o_sts.is_mul   = (r_op == OP_MUL);
    assign o_sts.is_div   = (r_op == OP_DIV) || (r_op == OP_MOD);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {6'd0, r_o_wval, r_o_widx, r_o_wr, r_o_offs, r_o_taken, r_o_status};

endmodule

@@ design/toy_cpu_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// Execute stage of a small register machine with stack and data memory.
// ----------------------------------------------------------------------------
// One instruction is taken at a time and gives one result transfer. After
// the input transfer, the operands are read one after another (second,
// third, first) through the single register file read port, then checked,
// and the result is committed. Multiply passes through a further state that
// registers its product; divide and modulo wait for the bit-serial divider.
// A finished result waits in an output register; the next instruction is
// accepted while it waits. Register file and data memory read as zero after
// reset.
module toy_cpu_execute_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // op[4:0], first_value[36:5], second_value[68:37], third_value[100:69]
    input  logic [tce_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // first_kind[1:0], second_kind[3:2], third_kind[5:4]
    input  logic [tce_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[3:0], branch_taken[4], branch_offset[36:5], reg_written[37],
    // written_index[41:38], written_value[73:42]
    output logic [tce_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tce_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
